// File: src/lpd_pkg.sv
package lpd_pkg;

   localparam int unsigned MAGIC_BYTES = 16;

   // result kinds, also used as micro-op codes in the queue
   localparam logic [1:0] KIND_START = 2'd0;
   localparam logic [1:0] KIND_PIXEL = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;
   localparam logic [1:0] KIND_CMD   = 2'd3;

   // configuration register indexes
   localparam logic CSR_PIXELS = 1'b0;
   localparam logic CSR_STRIPS = 1'b1;

   localparam logic [10:0] PIXELS_RESET = 11'd64;
   localparam logic [8:0]  STRIPS_RESET = 9'd8;
   localparam logic [10:0] PIXELS_MAX   = 11'd1024;

   localparam logic [7:0] MAGIC [MAGIC_BYTES] = '{
      8'h40, 8'h09, 8'h2d, 8'ha6, 8'h15, 8'ha5, 8'hdd, 8'he5,
      8'h6a, 8'h9d, 8'h4d, 8'h5a, 8'hcf, 8'h09, 8'haf, 8'h50
   };

   // work item from the front to the back
   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data;
      logic        flag;       // full update for start, valid for command
      logic        final_op;   // last op caused by one input request
      logic [31:0] seq;
      logic [31:0] lost;
   } op_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        full_update;
      logic [7:0]  strip_id;
      logic [9:0]  pixel_x;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [7:0]  command_data;
      logic        command_valid;
      logic [31:0] packet_sequence;
      logic [31:0] lost_total;
      logic        run_last;
   } result_type;

endpackage

// File: src/lpd_front.sv
module lpd_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        data_byte,
   input  logic              first_byte,
   input  logic [15:0]       packet_length,
   input  logic [11:0]       rec_len,
   input  logic [8:0]        strip_count,
   output logic              op_push,
   output lpd_pkg::op_type   op_data,
   input  logic              op_full
);

   localparam logic [2:0] M_IDLE   = 3'd0;
   localparam logic [2:0] M_SEQ    = 3'd1;
   localparam logic [2:0] M_LOOK   = 3'd2;
   localparam logic [2:0] M_CMD    = 3'd3;
   localparam logic [2:0] M_PIX    = 3'd4;
   localparam logic [2:0] M_REPLAY = 3'd5;

   logic [2:0]  mode_ff, mode_in;
   logic [15:0] pos_ff, pos_in;
   logic [15:0] exp_ff, exp_in;
   logic [31:0] seq_ff, seq_in;
   logic        match_ff, match_in;
   logic [31:0] prev_ff, prev_in;
   logic [31:0] lost_ff, lost_in;
   logic [4:0]  rep_idx_ff, rep_idx_in;
   logic [4:0]  rep_cnt_ff, rep_cnt_in;
   logic        rep_end_ff, rep_end_in;
   logic [7:0]  look_ff [lpd_pkg::MAGIC_BYTES];
   logic        look_we;
   logic [3:0]  look_k;

   logic        div_busy_ff, div_busy_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic [15:0] div_q_ff, div_q_in;
   logic [11:0] div_r_ff, div_r_in;
   logic [12:0] div_t;

   logic        accept;
   logic        div_start;

   assign req_tready = !div_busy_ff && !op_full && (mode_ff != M_REPLAY);
   assign accept     = req_tvalid && req_tready;

   // restoring divider: remaining bytes over record length, one bit a cycle
   always_comb begin
      div_t      = {div_r_ff, div_q_ff[15]};
      div_busy_in = div_busy_ff;
      div_cnt_in = div_cnt_ff;
      div_q_in   = div_q_ff;
      div_r_in   = div_r_ff;
      if (div_start) begin
         div_busy_in = 1'b1;
         div_cnt_in  = 5'd16;
         div_q_in    = packet_length - 16'd4;
         div_r_in    = '0;
      end else if (div_busy_ff) begin
         if (div_t >= {1'b0, rec_len}) begin
            div_r_in = 12'(div_t - {1'b0, rec_len});
            div_q_in = {div_q_ff[14:0], 1'b1};
         end else begin
            div_r_in = div_t[11:0];
            div_q_in = {div_q_ff[14:0], 1'b0};
         end
         div_cnt_in = div_cnt_ff - 5'd1;
         if (div_cnt_ff == 5'd1) begin
            div_busy_in = 1'b0;
         end
      end
   end

   always_comb begin
      logic [2:0]  m;
      logic [15:0] p;
      logic [15:0] e;
      logic [31:0] s;
      logic        mt;
      logic        at_last;
      logic        decide;
      logic [4:0]  held;
      logic [31:0] d;
      logic [32:0] sum;
      m = mode_ff;
      p = pos_ff;
      e = exp_ff;
      s = seq_ff;
      mt = match_ff;
      at_last = 1'b0;
      decide = 1'b0;
      held = '0;
      d = '0;
      sum = '0;
      mode_in = mode_ff;
      pos_in = pos_ff;
      exp_in = exp_ff;
      seq_in = seq_ff;
      match_in = match_ff;
      prev_in = prev_ff;
      lost_in = lost_ff;
      rep_idx_in = rep_idx_ff;
      rep_cnt_in = rep_cnt_ff;
      rep_end_in = rep_end_ff;
      look_we = 1'b0;
      look_k = '0;
      div_start = 1'b0;
      op_push = 1'b0;
      op_data = '0;
      if (accept) begin
         if (first_byte) begin
            e = packet_length;
            p = '0;
            s = '0;
            mt = 1'b1;
            m = (packet_length < 16'd4) ? M_IDLE : M_SEQ;
            div_start = 1'b1;
         end
         at_last = ({1'b0, p} + 17'd1) == {1'b0, e};
         mode_in = m;
         unique case (m)
            M_IDLE: begin
            end
            M_SEQ: begin
               s = s | (32'(data_byte) << {p[1:0], 3'b000});
               if (p >= 16'd3) begin
                  if (at_last) begin
                     decide = 1'b1;
                  end else begin
                     mode_in = M_LOOK;
                  end
               end
            end
            M_LOOK: begin
               look_k = 4'(p - 16'd4);
               look_we = 1'b1;
               if (data_byte != lpd_pkg::MAGIC[look_k]) begin
                  mt = 1'b0;
               end
               if (look_k == 4'hf && mt) begin
                  if (at_last) begin
                     op_push = 1'b1;
                     op_data.kind = lpd_pkg::KIND_CMD;
                     op_data.final_op = 1'b1;
                     mode_in = M_IDLE;
                  end else begin
                     mode_in = M_CMD;
                  end
               end else if (look_k == 4'hf || at_last) begin
                  decide = 1'b1;
                  held = {1'b0, look_k} + 5'd1;
               end
            end
            M_CMD: begin
               op_push = 1'b1;
               op_data.kind = lpd_pkg::KIND_CMD;
               op_data.data = data_byte;
               op_data.flag = 1'b1;
               op_data.final_op = 1'b1;
               if (at_last) begin
                  mode_in = M_IDLE;
               end
            end
            M_PIX: begin
               op_push = 1'b1;
               op_data.kind = lpd_pkg::KIND_PIXEL;
               op_data.data = data_byte;
               op_data.final_op = !at_last;
               if (at_last) begin
                  mode_in = M_REPLAY;
                  rep_idx_in = '0;
                  rep_cnt_in = '0;
                  rep_end_in = 1'b1;
               end
            end
            default: begin
               mode_in = M_IDLE;
            end
         endcase
         if (decide) begin
            if (div_r_ff == 12'd0) begin
               op_push = 1'b1;
               op_data.kind = lpd_pkg::KIND_START;
               op_data.flag = (div_q_ff == {7'd0, strip_count});
               mode_in = M_REPLAY;
               rep_idx_in = '0;
               rep_cnt_in = held;
               rep_end_in = at_last;
            end else begin
               mode_in = M_IDLE;
            end
         end
         pos_in = p + 16'd1;
         exp_in = e;
         seq_in = s;
         match_in = mt;
      end else if (mode_ff == M_REPLAY && !op_full) begin
         op_push = 1'b1;
         if (rep_idx_ff < rep_cnt_ff) begin
            op_data.kind = lpd_pkg::KIND_PIXEL;
            op_data.data = look_ff[rep_idx_ff[3:0]];
            op_data.final_op = (rep_idx_ff + 5'd1 == rep_cnt_ff) && !rep_end_ff;
            rep_idx_in = rep_idx_ff + 5'd1;
            if (rep_idx_ff + 5'd1 == rep_cnt_ff && !rep_end_ff) begin
               mode_in = M_PIX;
            end
         end else begin
            // frame end: count skipped sequence numbers, saturate
            d = seq_ff - prev_ff - 32'd1;
            if (d != 32'd0 && !d[31]) begin
               sum = {1'b0, lost_ff} + {1'b0, d};
               lost_in = sum[32] ? '1 : sum[31:0];
            end
            prev_in = seq_ff;
            op_data.kind = lpd_pkg::KIND_END;
            op_data.final_op = 1'b1;
            op_data.seq = seq_ff;
            op_data.lost = lost_in;
            mode_in = M_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= M_IDLE;
         pos_ff <= '0;
         exp_ff <= '0;
         seq_ff <= '0;
         match_ff <= 1'b1;
         prev_ff <= '1;
         lost_ff <= '0;
         rep_idx_ff <= '0;
         rep_cnt_ff <= '0;
         rep_end_ff <= 1'b0;
         div_busy_ff <= 1'b0;
         div_cnt_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         pos_ff <= pos_in;
         exp_ff <= exp_in;
         seq_ff <= seq_in;
         match_ff <= match_in;
         prev_ff <= prev_in;
         lost_ff <= lost_in;
         rep_idx_ff <= rep_idx_in;
         rep_cnt_ff <= rep_cnt_in;
         rep_end_ff <= rep_end_in;
         div_busy_ff <= div_busy_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      div_q_ff <= div_q_in;
      div_r_ff <= div_r_in;
      if (look_we) begin
         look_ff[look_k] <= data_byte;
      end
   end

   a_no_accept_while_div: assert property (@(posedge clock) disable iff (reset)
      div_busy_ff |-> !accept) else $error("byte taken while divider busy");
   a_replay_bound: assert property (@(posedge clock) disable iff (reset)
      (mode_ff == M_REPLAY) |-> (rep_idx_ff <= rep_cnt_ff && rep_cnt_ff <= 5'd16))
      else $error("replay index out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      op_full |-> !op_push) else $error("push into full queue");

endmodule

// File: src/lpd_fifo.sv
module lpd_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  lpd_pkg::op_type push_data,
   output logic            full,
   input  logic            pop,
   output logic            valid,
   output lpd_pkg::op_type pop_data
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   lpd_pkg::op_type mem_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in;
   logic [AW-1:0]   rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;

   assign full     = (cnt_ff == (AW+1)'(DEPTH));
   assign valid    = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + (AW+1)'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - (AW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (AW+1)'(DEPTH)) else $error("queue count overflow");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> valid) else $error("pop from empty queue");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |-> !full) else $error("push into full queue");

endmodule

// File: src/lpd_back.sv
module lpd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               op_valid,
   input  lpd_pkg::op_type    op_data,
   output logic               op_pop,
   input  logic [11:0]        rec_len,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output lpd_pkg::result_type rsp_result
);

   lpd_pkg::result_type h_ff, h_in;
   logic                h_valid_ff, h_valid_in;
   lpd_pkg::result_type o_ff, o_in;
   logic                o_valid_ff, o_valid_in;
   logic [11:0]         off_ff, off_in;
   logic [1:0]          phase_ff, phase_in;
   logic [9:0]          x_ff, x_in;
   logic [7:0]          strip_ff, strip_in;
   logic [7:0]          red_ff, red_in;
   logic [7:0]          green_ff, green_in;

   logic                o_free;
   logic                emit;
   lpd_pkg::result_type res;

   assign rsp_tvalid = o_valid_ff;
   assign rsp_result = o_ff;
   assign o_free     = !o_valid_ff || rsp_tready;
   assign op_pop     = op_valid && (!h_valid_ff || o_free);

   always_comb begin
      logic [12:0] nxt;
      nxt = {1'b0, off_ff} + 13'd1;
      emit = 1'b0;
      res = '0;
      off_in = off_ff;
      phase_in = phase_ff;
      x_in = x_ff;
      strip_in = strip_ff;
      red_in = red_ff;
      green_in = green_ff;
      if (op_pop) begin
         unique case (op_data.kind)
            lpd_pkg::KIND_START: begin
               emit = 1'b1;
               res.kind = lpd_pkg::KIND_START;
               res.full_update = op_data.flag;
               off_in = '0;
            end
            lpd_pkg::KIND_PIXEL: begin
               if (off_ff == 12'd0) begin
                  strip_in = op_data.data;
                  phase_in = 2'd0;
                  x_in = '0;
               end else begin
                  case (phase_ff)
                     2'd0: begin
                        red_in = op_data.data;
                        phase_in = 2'd1;
                     end
                     2'd1: begin
                        green_in = op_data.data;
                        phase_in = 2'd2;
                     end
                     default: begin
                        emit = 1'b1;
                        res.kind = lpd_pkg::KIND_PIXEL;
                        res.strip_id = strip_ff;
                        res.pixel_x = x_ff;
                        res.red = red_ff;
                        res.green = green_ff;
                        res.blue = op_data.data;
                        x_in = x_ff + 10'd1;
                        phase_in = 2'd0;
                     end
                  endcase
               end
               off_in = (nxt >= {1'b0, rec_len}) ? '0 : nxt[11:0];
            end
            lpd_pkg::KIND_END: begin
               emit = 1'b1;
               res.kind = lpd_pkg::KIND_END;
               res.packet_sequence = op_data.seq;
               res.lost_total = op_data.lost;
            end
            default: begin
               emit = 1'b1;
               res.kind = lpd_pkg::KIND_CMD;
               res.command_data = op_data.data;
               res.command_valid = op_data.flag;
            end
         endcase
         res.run_last = op_data.final_op;
      end
   end

   // hold the newest result until it is known whether it ends its request
   always_comb begin
      logic h_last;
      h_last = h_ff.run_last || (op_pop && !emit && op_data.final_op);
      h_in = h_ff;
      h_valid_in = h_valid_ff;
      o_in = o_ff;
      o_valid_in = o_valid_ff && !rsp_tready;
      if (op_pop && emit) begin
         if (h_valid_ff) begin
            o_in = h_ff;
            o_valid_in = 1'b1;
         end
         h_in = res;
         h_valid_in = 1'b1;
      end else if (h_valid_ff && h_last && o_free) begin
         o_in = h_ff;
         o_in.run_last = 1'b1;
         o_valid_in = 1'b1;
         h_valid_in = 1'b0;
      end else if (h_valid_ff) begin
         h_in.run_last = h_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         h_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
         off_ff <= '0;
         phase_ff <= '0;
         x_ff <= '0;
      end else begin
         h_valid_ff <= h_valid_in;
         o_valid_ff <= o_valid_in;
         off_ff <= off_in;
         phase_ff <= phase_in;
         x_ff <= x_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff <= h_in;
      o_ff <= o_in;
      strip_ff <= strip_in;
      red_ff <= red_in;
      green_ff <= green_in;
   end

   a_cmd_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.kind == lpd_pkg::KIND_CMD) |-> rsp_result.run_last)
      else $error("command byte not marked last");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_result.kind == lpd_pkg::KIND_END) |-> rsp_result.run_last)
      else $error("frame end not marked last");
   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff != 2'd3) else $error("colour phase out of range");

endmodule

// File: src/led_pixel_packet_deframer.sv
// channel | ports             | carries
// ------- | ----------------- | ------------------------------------------------------
// request | req_t*            | tdata byte+length, tuser first byte, tlast (unused)
// result  | rsp_t*            | tdata result fields, tuser kind, tlast last of request
// config  | csr_we/addr/wdata | 0 pixels per record, 1 strip_count
//
// Requests are normally taken one a cycle. A first byte starts a bit-serial division
// of the payload length by the record length; no request is taken while it runs.
// A pixel decision replays up to 16 held bytes into the queue at one a cycle unless
// it is full, then the frame end if the packet ended. Reset is synchronous and clears
// all control state. The op queue decouples the front from the result register, so a
// stalled result side backs up into the request side only once the queue is full.
module led_pixel_packet_deframer #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [23:0]  req_tdata,   // data_byte[7:0], packet_length[23:8]
   input  logic         req_tuser,   // first_byte
   input  logic         req_tlast,   // last_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // full_update[0], strip_id[8:1], pixel_x[18:9], red[26:19],
   // green[34:27], blue[42:35], command_data[50:43], command_valid[51],
   // packet_sequence[83:52], lost_total[115:84], zero fill[119:116]
   output logic [119:0] rsp_tdata,
   output logic [1:0]   rsp_tuser,   // kind
   output logic         rsp_tlast,   // run_last
   input  logic         csr_we,
   input  logic         csr_addr,
   input  logic [10:0]  csr_wdata
);

   logic [10:0] pixels_ff;
   logic [8:0]  strips_ff;
   logic [10:0] pixels_eff;
   logic [11:0] rec_len;

   logic                op_push;
   lpd_pkg::op_type     op_in_data;
   logic                op_full;
   logic                op_valid;
   logic                op_pop;
   lpd_pkg::op_type     op_out_data;
   lpd_pkg::result_type result;

   // hold the configuration; user writes must happen only while idle; not enforced here
   always_ff @(posedge clock) begin
      if (reset) begin
         pixels_ff <= lpd_pkg::PIXELS_RESET;
         strips_ff <= lpd_pkg::STRIPS_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            lpd_pkg::CSR_PIXELS: pixels_ff <= csr_wdata;
            lpd_pkg::CSR_STRIPS: strips_ff <= csr_wdata[8:0];
            default: begin
            end
         endcase
      end
   end

   // record length: one strip byte plus three colour bytes a pixel
   assign pixels_eff = (pixels_ff > lpd_pkg::PIXELS_MAX) ? lpd_pkg::PIXELS_MAX : pixels_ff;
   assign rec_len    = {pixels_eff, 1'b0} + {1'b0, pixels_eff} + 12'd1;

   lpd_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .data_byte     (req_tdata[7:0]),
      .first_byte    (req_tuser),
      .packet_length (req_tdata[23:8]),
      .rec_len       (rec_len),
      .strip_count   (strips_ff),
      .op_push       (op_push),
      .op_data       (op_in_data),
      .op_full       (op_full)
   );

   lpd_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_in_data),
      .full      (op_full),
      .pop       (op_pop),
      .valid     (op_valid),
      .pop_data  (op_out_data)
   );

   lpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .op_valid   (op_valid),
      .op_data    (op_out_data),
      .op_pop     (op_pop),
      .rec_len    (rec_len),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_result (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tlast = result.run_last;
   assign rsp_tdata = {4'd0, result.lost_total, result.packet_sequence,
                       result.command_valid, result.command_data, result.blue,
                       result.green, result.red, result.pixel_x,
                       result.strip_id, result.full_update};

   // last byte mark is not used: packet length alone bounds a packet
   logic unused_last;
   assign unused_last = req_tlast;

endmodule

// File: bench/led_pixel_packet_deframer_test.sv
module led_pixel_packet_deframer_test;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_SEQ, MODE_LOOK, MODE_CMD, MODE_PIX
   } parse_mode_type;

   typedef bit [7:0] byte_queue_type[$];

   // Deframer predictor plus the queue of results it still waits for.
   class deframer_board;
      bit [10:0]      pixels = lpd_pkg::PIXELS_RESET;
      bit [8:0]       strips = lpd_pkg::STRIPS_RESET;
      bit [15:0]      position, length;
      parse_mode_type mode = MODE_IDLE;
      bit [7:0]       held[lpd_pkg::MAGIC_BYTES];
      bit [31:0]      sequence_no, prev_sequence = '1, lost;
      int unsigned    rec_offset;
      bit [7:0]       cur_strip;
      bit [15:0]      colour;
      bit             magic_ok = 1;
      lpd_pkg::result_type pending[$];
      int             errors;

      function int unsigned rec_len();
         return 1 + 3 * ((pixels > lpd_pkg::PIXELS_MAX) ? lpd_pkg::PIXELS_MAX : pixels);
      endfunction

      function void add(bit [1:0] kind, lpd_pkg::result_type r);
         r.kind = kind;
         pending.push_back(r);
      endfunction

      function void feed(bit [7:0] b);
         lpd_pkg::result_type r;
         int unsigned k;
         r = '0;
         if (rec_offset == 0) begin
            cur_strip = b;
         end else begin
            k = rec_offset - 1;
            case (k % 3)
               0: colour = {b, 8'h00};
               1: colour[7:0] = b;
               default: begin
                  r.strip_id = cur_strip;
                  r.pixel_x = k / 3;
                  r.red = colour[15:8];
                  r.green = colour[7:0];
                  r.blue = b;
                  add(lpd_pkg::KIND_PIXEL, r);
               end
            endcase
         end
         rec_offset++;
         if (rec_offset >= rec_len()) rec_offset = 0;
      endfunction

      function void close_frame();
         lpd_pkg::result_type r;
         bit [31:0] gap, sum;
         r = '0;
         gap = sequence_no - prev_sequence - 1;
         // only a forward jump counts as lost packets; total saturates
         if (gap != 0 && gap < 32'h8000_0000) begin
            sum = lost + gap;
            lost = (sum < lost) ? '1 : sum;
         end
         prev_sequence = sequence_no;
         r.packet_sequence = sequence_no;
         r.lost_total = lost;
         add(lpd_pkg::KIND_END, r);
      endfunction

      function void decide_pixels(int unsigned count, bit at_last);
         lpd_pkg::result_type r;
         int unsigned remaining;
         r = '0;
         remaining = length - 4;
         // drop the packet silently unless it holds whole records
         if (remaining % rec_len() != 0) begin
            mode = MODE_IDLE;
            return;
         end
         r.full_update = (remaining / rec_len()) == strips;
         add(lpd_pkg::KIND_START, r);
         rec_offset = 0;
         for (int i = 0; i < count; i++) feed(held[i]);
         if (at_last) begin
            close_frame();
            mode = MODE_IDLE;
         end else begin
            mode = MODE_PIX;
         end
      endfunction

      // Note one accepted request and queue the results it causes.
      function void note_request(bit [7:0] b, bit first, bit [15:0] len);
         lpd_pkg::result_type r;
         int before_count, k;
         bit at_last;
         r = '0;
         before_count = pending.size();
         if (first) begin
            length = len;
            position = 0;
            sequence_no = 0;
            rec_offset = 0;
            colour = 0;
            magic_ok = 1;
            mode = (len < 4) ? MODE_IDLE : MODE_SEQ;
         end
         if (mode == MODE_IDLE) return;
         at_last = (32'(position) + 1 == 32'(length));
         case (mode)
            MODE_SEQ: begin
               sequence_no |= 32'(b) << (8 * position[1:0]);
               if (position >= 3) begin
                  if (at_last) decide_pixels(0, 1);
                  else mode = MODE_LOOK;
               end
            end
            MODE_LOOK: begin
               k = (position - 4) & (lpd_pkg::MAGIC_BYTES - 1);
               held[k] = b;
               if (b != lpd_pkg::MAGIC[k]) magic_ok = 0;
               if (k == lpd_pkg::MAGIC_BYTES - 1 && magic_ok) begin
                  if (at_last) begin
                     // magic with nothing after it: empty command marker
                     add(lpd_pkg::KIND_CMD, r);
                     mode = MODE_IDLE;
                  end else begin
                     mode = MODE_CMD;
                  end
               end else if (k == lpd_pkg::MAGIC_BYTES - 1 || at_last) begin
                  decide_pixels(k + 1, at_last);
               end
            end
            MODE_CMD: begin
               r.command_data = b;
               r.command_valid = 1;
               add(lpd_pkg::KIND_CMD, r);
               if (at_last) mode = MODE_IDLE;
            end
            MODE_PIX: begin
               feed(b);
               if (at_last) begin
                  close_frame();
                  mode = MODE_IDLE;
               end
            end
            default: mode = MODE_IDLE;
         endcase
         position++;
         if (pending.size() > before_count) pending[pending.size() - 1].run_last = 1;
      endfunction

      function void field(string name, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
         end
      endfunction

      // Compare one accepted result with the oldest expected one.
      function void check_result(lpd_pkg::result_type got);
         lpd_pkg::result_type want;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t unexpected result: expected none actual %h", $time, got);
            return;
         end
         want = pending.pop_front();
         field("kind", want.kind, got.kind);
         field("full_update", want.full_update, got.full_update);
         field("strip_id", want.strip_id, got.strip_id);
         field("pixel_x", want.pixel_x, got.pixel_x);
         field("red", want.red, got.red);
         field("green", want.green, got.green);
         field("blue", want.blue, got.blue);
         field("command_data", want.command_data, got.command_data);
         field("command_valid", want.command_valid, got.command_valid);
         field("packet_sequence", want.packet_sequence, got.packet_sequence);
         field("lost_total", want.lost_total, got.lost_total);
         field("run_last", want.run_last, got.run_last);
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_tvalid = 0;
   logic         req_tready;
   logic [23:0]  req_tdata = '0;
   logic         req_tuser = 0;
   logic         req_tlast = 0;
   logic         rsp_tvalid;
   logic         rsp_tready = 0;
   logic [119:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;
   logic         csr_we = 0;
   logic         csr_addr = 0;
   logic [10:0]  csr_wdata = '0;

   deframer_board board = new();
   int            send_idle_pct;   // chance of a gap before a request
   int            stall_pct;       // chance per cycle of the receiver stalling
   int            hold_left;       // long hold-off, counted down by the receiver
   int            phase_items;
   bit [31:0]     seq_counter;

   led_pixel_packet_deframer i_dut (.*);

   initial forever #2 clock = ~clock;

   initial begin
      #4_000_000;
      $display("FAIL led_pixel_packet_deframer");
      $finish;
   end

   // Receiver: check every accepted result, then pick next cycle's ready.
   initial begin
      lpd_pkg::result_type got;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) begin
            got.kind = rsp_tuser;
            {got.lost_total, got.packet_sequence, got.command_valid, got.command_data,
             got.blue, got.green, got.red, got.pixel_x, got.strip_id,
             got.full_update} = rsp_tdata[115:0];
            got.run_last = rsp_tlast;
            board.check_result(got);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 0;
         end else begin
            rsp_tready <= !reset && ($urandom_range(99) >= stall_pct);
         end
      end
   end

   // Offer one request, hold it until taken, then note it.
   task automatic send_req(input bit [7:0] b, input bit first, input bit last,
                           input bit [15:0] len);
      int gap;
      gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(3, 1) : 0;
      if (gap > 0) begin
         req_tvalid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1;
      req_tdata <= {len, b};
      req_tuser <= first;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      board.note_request(b, first, len);
   endtask

   // Send a body under a given length field; last marks follow the length.
   task automatic send_packet(input byte_queue_type body, input int unsigned len_field);
      foreach (body[i])
         send_req(body[i], i == 0, i + 1 == len_field, len_field[15:0]);
      phase_items += body.size();
   endtask

   task automatic wait_drained();
      while (board.pending.size() != 0) @(posedge clock);
      // a dropped packet or the length division may still be in flight
      repeat (60) @(posedge clock);
   endtask

   task automatic write_csr(input logic addr, input bit [10:0] value);
      @(posedge clock);
      csr_we <= 1;
      csr_addr <= addr;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 0;
      if (addr == lpd_pkg::CSR_PIXELS) board.pixels = value;
      else board.strips = value[8:0];
   endtask

   function automatic byte_queue_type seq_bytes(bit [31:0] s);
      return '{s[7:0], s[15:8], s[23:16], s[31:24]};
   endfunction

   function automatic bit [31:0] pick_sequence();
      int r;
      r = $urandom_range(99);
      if (r < 70) seq_counter += 1;
      else if (r < 85) seq_counter += $urandom_range(5, 2);
      else if (r < 95) seq_counter = $urandom;
      return seq_counter;
   endfunction

   function automatic byte_queue_type pixel_body(int unsigned records, bit [31:0] s);
      byte_queue_type body;
      body = seq_bytes(s);
      repeat (records * board.rec_len()) body.push_back($urandom_range(255));
      return body;
   endfunction

   function automatic byte_queue_type command_body(int unsigned count, bit [31:0] s,
                                                   bit spoil);
      byte_queue_type body;
      body = seq_bytes(s);
      for (int i = 0; i < lpd_pkg::MAGIC_BYTES; i++) body.push_back(lpd_pkg::MAGIC[i]);
      if (spoil)
         body[4 + $urandom_range(lpd_pkg::MAGIC_BYTES - 1)] ^= 8'(1 << $urandom_range(7));
      repeat (count) body.push_back($urandom_range(255));
      return body;
   endfunction

   function automatic byte_queue_type random_body(int unsigned count);
      byte_queue_type body;
      repeat (count) body.push_back($urandom_range(255));
      return body;
   endfunction

   // Close any open packet with a length under four so registers can change.
   task automatic close_packet();
      send_req($urandom_range(255), 1, 1, 16'd0);
   endtask

   task automatic random_packet();
      byte_queue_type body;
      int r, cut, records;
      r = $urandom_range(99);
      if (r < 45) begin
         // a whole wide record would swamp the run: wide strips get empty frames
         if (board.rec_len() > 25) begin
            records = 0;
         end else begin
            records = ($urandom_range(3) == 0 && board.strips <= 4) ? board.strips
                                                                    : $urandom_range(3);
         end
         body = pixel_body(records, pick_sequence());
         send_packet(body, body.size());
      end else if (r < 65) begin
         body = command_body($urandom_range(6), pick_sequence(), $urandom_range(3) == 0);
         send_packet(body, body.size());
      end else if (r < 80) begin
         body = random_body($urandom_range(24));
         if (body.size() == 0) body.push_back($urandom_range(255));
         send_packet(body, body.size());
      end else if (r < 90) begin
         // truncate: the next first byte abandons this packet
         body = ($urandom_range(1) == 0) ? command_body(4, pick_sequence(), 0)
                                         : pixel_body(2, pick_sequence());
         cut = $urandom_range((body.size() > 30) ? 30 : body.size() - 1, 1);
         send_packet(body[0:cut - 1],
                     ($urandom_range(1) == 0) ? body.size() : $urandom_range(65535, 4));
      end else begin
         // overlong: bytes after the declared end are ignored
         body = command_body($urandom_range(3), pick_sequence(), 0);
         send_packet(body, body.size());
         repeat ($urandom_range(3, 1))
            send_req($urandom_range(255), 0, $urandom_range(1), $urandom_range(65535));
      end
   endtask

   initial begin
      bit [10:0] pixel_set[8] = '{11'd1, 11'd2, 11'd3, 11'd0, 11'd1, 11'd2047, 11'd1024, 11'd4};
      bit [10:0] strip_set[8] = '{11'd2, 11'd1, 11'd256, 11'd0, 11'd511, 11'd3, 11'd1, 11'd5};
      byte_queue_type body;

      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: short packets, empty and filled commands, a full update,
      // a wrong-size drop and a saturating lost count
      write_csr(lpd_pkg::CSR_PIXELS, 11'd1);
      write_csr(lpd_pkg::CSR_STRIPS, 11'd2);
      send_packet(seq_bytes(32'h0000_0000), 4);
      send_packet(random_body(3), 3);
      send_packet(command_body(0, 32'hffff_ffff, 0), 20);
      body = command_body(2, 32'h0000_0005, 0);
      body[20] = 8'hff;
      send_packet(body, body.size());
      body = pixel_body(2, 32'h0000_0001);
      body[4] = 8'hff;
      send_packet(body, body.size());
      send_packet(random_body(9), 9);
      send_packet(seq_bytes(32'h8000_0001), 4);
      send_packet(seq_bytes(32'h0000_0001), 4);
      send_packet(seq_bytes(32'h8000_0001), 4);
      seq_counter = 32'h8000_0001;
      close_packet();
      req_tvalid <= 0;
      wait_drained();

      for (int p = 0; p < 8; p++) begin
         case (p % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 66; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 66; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         write_csr(lpd_pkg::CSR_PIXELS, pixel_set[p]);
         write_csr(lpd_pkg::CSR_STRIPS, strip_set[p]);
         // hold off the receiver so the queue fills and the front stalls
         if (p == 4) hold_left = 400;
         phase_items = 0;
         while (phase_items < 30) random_packet();
         close_packet();
         req_tvalid <= 0;
         wait_drained();
      end

      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("PASS led_pixel_packet_deframer");
      end else begin
         $display("FAIL led_pixel_packet_deframer");
      end
      $finish;
   end
endmodule
